// ===== design/mtsd_pkg.sv =====
`default_nettype none

package mtsd_pkg;

    localparam int MAX_NOTES      = 32;
    localparam int NOTE_IDX_W     = $clog2(MAX_NOTES);
    localparam int NOTE_CNT_W     = $clog2(MAX_NOTES + 1);
    localparam int SINE_ADDR_BITS = 10;
    localparam int QUARTER        = 2 ** (SINE_ADDR_BITS - 2);
    localparam int QADDR_W        = SINE_ADDR_BITS - 2;

    localparam int PHASE_W   = 16;
    localparam int DUR_W     = 20;
    localparam int VOLUME_W  = 15;
    localparam int NCOUNT_W  = 6;
    localparam int SAMPLE_W  = 16;
    localparam int MAG_W     = 15;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [NCOUNT_W-1:0] NOTE_COUNT_RST = NCOUNT_W'(18);
    localparam logic [VOLUME_W-1:0] VOLUME_RST     = VOLUME_W'(8000);
    localparam logic [MAG_W-1:0]    SINE_PEAK      = MAG_W'(32767);

    // register select bit of paddr
    localparam logic REG_IDX_NOTE_COUNT = 1'b0;
    localparam logic REG_IDX_VOLUME     = 1'b1;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_START = 2'd1,
        KIND_STOP  = 2'd2,
        KIND_TICK  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]   sample;
        logic                  sample_valid;
        logic [NOTE_IDX_W-1:0] note_position;
        logic                  playing;
        logic                  finished;
    } result_t;

    typedef logic [MAG_W-1:0] qsine_t [QUARTER];

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    typedef logic [63:0] series_div_t [8];
    localparam series_div_t SERIES_DIV = '{64'd1, 64'd6, 64'd20, 64'd42, 64'd72,
                                           64'd110, 64'd156, 64'd210};

    // quarter wave of round(32767 * sin), Taylor series in Q30
    function automatic qsine_t build_qsine();
        qsine_t      t;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] s;
        logic [63:0] v;
        for (int r = 0; r < QUARTER; r++) begin
            x    = (HALF_PI_Q30 * 64'(r)) / QUARTER;
            x2   = (x * x) >> 30;
            term = x;
            pos  = x;
            neg  = 64'd0;
            for (int k = 1; k <= 7; k++) begin
                term = (term * x2) >> 30;
                term = term / SERIES_DIV[k];
                if ((k % 2) == 1) begin
                    neg = neg + term;
                end else begin
                    pos = pos + term;
                end
            end
            if (neg >= pos) begin
                s = 64'd0;
            end else begin
                s = pos - neg;
                if (s > ONE_Q30) begin
                    s = ONE_Q30;
                end
            end
            v    = (s * 64'd32767 + (64'd1 << 29)) >> 30;
            t[r] = v[MAG_W-1:0];
        end
        return t;
    endfunction

    localparam qsine_t QSINE = build_qsine();

endpackage

`default_nettype wire

// ===== design/melody_tone_sequencer_dds.sv =====
// Melody player built on a 16-bit phase accumulator and a sine table. Every input beat
// yields exactly one output beat; beats are taken one per clock cycle while the skid entry
// is empty. Each result comes from a combinational path: quarter-wave table lookup of the
// phase, one 15x15 volume multiply and the duration compare. It is registered in the
// output register, or in the skid entry when the output is stalled; this two-entry buffer
// lets the input take one more beat. tuser on the input selects load, start, stop or tick;
// load beats write one of MAX_NOTES melody slots. note_count and volume sit at byte
// addresses 0 and 4 of the register port and should only be written when idle.
`default_nettype none

module melody_tone_sequencer_dds
    import mtsd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output      logic [PDATA_W-1:0]  prdata,
    output      logic                pready,

    input  wire logic                s_axis_tvalid,
    output      logic                s_axis_tready,
    // entry_index, entry_increment, entry_duration, zero fill
    input  wire logic [47:0]         s_axis_tdata,
    // kind
    input  wire logic [1:0]          s_axis_tuser,

    output      logic                m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // sample, note_position, playing, zero fill
    output      logic [23:0]         m_axis_tdata,
    // sample_valid
    output      logic                m_axis_tuser,
    // finished
    output      logic                m_axis_tlast
);

    logic [NCOUNT_W-1:0]   note_count_reg;
    logic [VOLUME_W-1:0]   volume_reg;

    logic [PHASE_W-1:0]    inc_mem [MAX_NOTES];
    logic [DUR_W-1:0]      dur_mem [MAX_NOTES];

    logic [PHASE_W-1:0]    phase_reg, phase_next;
    logic [DUR_W-1:0]      counter_reg, counter_next;
    logic [NOTE_IDX_W-1:0] note_reg, note_next;
    logic                  active_reg, active_next;

    result_t               out_reg, skid_reg, result;
    logic                  out_valid_reg, skid_valid_reg;

    kind_t                 kind;
    logic [NOTE_IDX_W-1:0] entry_index;
    logic [PHASE_W-1:0]    entry_increment;
    logic [DUR_W-1:0]      entry_duration;
    logic                  accept_in;
    logic                  out_fire;
    logic                  cfg_write;

    logic [NOTE_CNT_W-1:0]     notes_in_use;
    logic [PHASE_W-1:0]        cur_inc;
    logic [DUR_W-1:0]          cur_dur;
    logic [SINE_ADDR_BITS-1:0] sine_addr;
    logic [QADDR_W:0]          quarter_arg;
    logic [MAG_W-1:0]          mag;
    logic [2*MAG_W-1:0]        product;
    logic [MAG_W-1:0]          scaled;
    logic [DUR_W:0]            counter_inc;
    logic [NOTE_CNT_W-1:0]     note_inc;
    logic                      note_done;

    assign kind            = kind_t'(s_axis_tuser);
    assign entry_index     = NOTE_IDX_W'(s_axis_tdata[4:0]);
    assign entry_increment = s_axis_tdata[20:5];
    assign entry_duration  = s_axis_tdata[40:21];

    assign s_axis_tready = !skid_valid_reg;
    assign accept_in     = s_axis_tvalid && s_axis_tready;
    assign out_fire      = out_valid_reg && m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg.playing, NOTE_IDX_W'(out_reg.note_position),
                            out_reg.sample};
    assign m_axis_tuser  = out_reg.sample_valid;
    assign m_axis_tlast  = out_reg.finished;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        if (paddr[2] == REG_IDX_VOLUME) begin
            prdata = PDATA_W'(volume_reg);
        end else begin
            prdata = PDATA_W'(note_count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            note_count_reg <= NOTE_COUNT_RST;
            volume_reg     <= VOLUME_RST;
        end else if (cfg_write) begin
            if (paddr[2] == REG_IDX_VOLUME) begin
                volume_reg <= pwdata[VOLUME_W-1:0];
            end else begin
                note_count_reg <= pwdata[NCOUNT_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (note_count_reg == '0) begin
            notes_in_use = NOTE_CNT_W'(1);
        end else if (32'(note_count_reg) > MAX_NOTES) begin
            notes_in_use = NOTE_CNT_W'(MAX_NOTES);
        end else begin
            notes_in_use = NOTE_CNT_W'(note_count_reg);
        end
    end

    // melody slots
    always_ff @(posedge clk)
    begin
        if (accept_in && kind == KIND_LOAD && 32'(s_axis_tdata[4:0]) < MAX_NOTES) begin
            inc_mem[entry_index] <= entry_increment;
            dur_mem[entry_index] <= entry_duration;
        end
    end

    assign cur_inc = inc_mem[note_reg];
    assign cur_dur = dur_mem[note_reg];

    // quarter-wave sine lookup and volume scaling
    assign sine_addr = phase_reg[PHASE_W-1 -: SINE_ADDR_BITS];

    always_comb
    begin
        if (sine_addr[SINE_ADDR_BITS-2]) begin
            quarter_arg = (QADDR_W+1)'(QUARTER) - {1'b0, sine_addr[QADDR_W-1:0]};
        end else begin
            quarter_arg = {1'b0, sine_addr[QADDR_W-1:0]};
        end
        if (quarter_arg[QADDR_W]) begin
            mag = SINE_PEAK;
        end else begin
            mag = QSINE[quarter_arg[QADDR_W-1:0]];
        end
    end

    assign product     = (2*MAG_W)'(mag) * (2*MAG_W)'(volume_reg);
    assign scaled      = product[2*MAG_W-1:MAG_W];
    assign counter_inc = {1'b0, counter_reg} + (DUR_W+1)'(1);
    assign note_inc    = NOTE_CNT_W'(note_reg) + NOTE_CNT_W'(1);
    assign note_done   = counter_inc >= {1'b0, cur_dur};

    always_comb
    begin
        phase_next   = phase_reg;
        counter_next = counter_reg;
        note_next    = note_reg;
        active_next  = active_reg;
        result       = '0;
        unique case (kind)
            KIND_LOAD:
            begin
            end
            KIND_START:
            begin
                if (!active_reg) begin
                    active_next  = 1'b1;
                    note_next    = '0;
                    phase_next   = '0;
                    counter_next = '0;
                end
            end
            KIND_STOP:
            begin
                active_next = 1'b0;
            end
            KIND_TICK:
            begin
                if (active_reg) begin
                    result.sample_valid  = 1'b1;
                    result.note_position = note_reg;
                    if (cur_inc != '0) begin
                        if (sine_addr[SINE_ADDR_BITS-1]) begin
                            result.sample = SAMPLE_W'(0) - {1'b0, scaled};
                        end else begin
                            result.sample = {1'b0, scaled};
                        end
                        phase_next = phase_reg + cur_inc;
                    end
                    counter_next = counter_inc[DUR_W-1:0];
                    if (note_done) begin
                        counter_next = '0;
                        phase_next   = '0;
                        note_next    = note_inc[NOTE_IDX_W-1:0];
                        if (note_inc >= notes_in_use) begin
                            active_next     = 1'b0;
                            result.finished = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        result.playing = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= '0;
            counter_reg <= '0;
            note_reg    <= '0;
            active_reg  <= 1'b0;
        end else if (accept_in) begin
            phase_reg   <= phase_next;
            counter_reg <= counter_next;
            note_reg    <= note_next;
            active_reg  <= active_next;
        end
    end

    // output register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_fire) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || out_fire) begin
            out_valid_reg <= accept_in;
        end else if (accept_in) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg) begin
            if (out_fire) begin
                out_reg <= skid_reg;
            end
        end else if (!out_valid_reg || out_fire) begin
            if (accept_in) begin
                out_reg <= result;
            end
        end else if (accept_in) begin
            skid_reg <= result;
        end
    end

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_finished_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.finished |-> !out_reg.playing && out_reg.sample_valid)
        else $error("finished beat while still playing");

    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.sample_valid |-> out_reg.sample == '0)
        else $error("non-zero sample outside playback");

    a_note_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> NOTE_CNT_W'(note_reg) < notes_in_use || $past(cfg_write))
        else $error("playing past the last note");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in && kind == KIND_START && !active_reg |=>
            active_reg && phase_reg == '0 && counter_reg == '0 && note_reg == '0)
        else $error("start did not clear the sequencer");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import mtsd_pkg::*;

    logic                clk;
    logic                rst_n;

    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    logic                s_axis_tvalid;
    logic                s_axis_tready;
    // entry_index, entry_increment, entry_duration, zero fill
    logic [47:0]         s_axis_tdata;
    // kind
    logic [1:0]          s_axis_tuser;

    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // sample, note_position, playing, zero fill
    logic [23:0]         m_axis_tdata;
    // sample_valid
    logic                m_axis_tuser;
    // finished
    logic                m_axis_tlast;

    localparam int SINE_N = 2 ** SINE_ADDR_BITS;

    // player model state
    int                  sine_wave [SINE_N];
    logic [15:0]         tone_step [MAX_NOTES];
    logic [19:0]         tone_len [MAX_NOTES];
    logic [15:0]         phase_acc;
    logic [20:0]         len_count;
    logic [5:0]          note_now;
    bit                  playing_now;
    logic [5:0]          note_count_reg;
    logic [14:0]         volume_reg;

    result_t             tone_results [$];
    result_t             want;
    bit                  quiet;
    int unsigned         failures;
    int unsigned         beats_sent;
    int unsigned         samples_played;
    int unsigned         melodies_done;
    int unsigned         reg_writes;

    melody_tone_sequencer_dds i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // sin of a quarter-wave step in Q30, Taylor series to eight terms
    function automatic longint unsigned sine_q30(input int unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        x    = (64'd1686629713 * r) / (SINE_N / 4);
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        neg  = 0;
        for (int k = 1; k <= 7; k++)
        begin
            term = (term * x2) >> 30;
            term = term / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                neg = neg + term;
            else
                pos = pos + term;
        end
        if (neg >= pos)
            return 0;
        pos = pos - neg;
        if (pos > (64'd1 << 30))
            pos = 64'd1 << 30;
        return pos;
    endfunction

    task automatic play_beat(input kind_t k, input logic [4:0] idx, input logic [15:0] inc,
                             input logic [19:0] dur);
        result_t     res;
        int          s;
        int unsigned mag;
        int unsigned scaled;
        int unsigned slot;
        int unsigned in_use;
        res = '0;
        case (k)
            KIND_LOAD:
            begin
                tone_step[idx] = inc;
                tone_len[idx]  = dur;
            end
            KIND_START:
            begin
                if (!playing_now)
                begin
                    playing_now = 1'b1;
                    note_now    = '0;
                    phase_acc   = '0;
                    len_count   = '0;
                end
            end
            KIND_STOP:
                playing_now = 1'b0;
            default:
            begin
                if (playing_now)
                begin
                    slot = (note_now < MAX_NOTES) ? note_now : MAX_NOTES - 1;
                    res.sample_valid  = 1'b1;
                    res.note_position = note_now[4:0];
                    samples_played++;
                    if (tone_step[slot] != 16'd0)
                    begin
                        s      = sine_wave[phase_acc >> (16 - SINE_ADDR_BITS)];
                        mag    = (s < 0) ? -s : s;
                        scaled = (mag * volume_reg) >> 15;
                        res.sample = (s < 0) ? 16'(-scaled) : 16'(scaled);
                        phase_acc  = phase_acc + tone_step[slot];
                    end
                    len_count = len_count + 21'd1;
                    if (len_count >= {1'b0, tone_len[slot]})
                    begin
                        len_count = '0;
                        phase_acc = '0;
                        note_now  = note_now + 6'd1;
                        if (note_count_reg == 0)
                            in_use = 1;
                        else if (note_count_reg > MAX_NOTES)
                            in_use = MAX_NOTES;
                        else
                            in_use = note_count_reg;
                        if (note_now >= in_use)
                        begin
                            playing_now  = 1'b0;
                            res.finished = 1'b1;
                            melodies_done++;
                        end
                    end
                end
            end
        endcase
        res.playing = playing_now;
        tone_results.push_back(res);
    endtask

    task automatic send_beat(input kind_t k, input logic [4:0] idx = '0,
                             input logic [15:0] inc = '0, input logic [19:0] dur = '0);
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < 36)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= k;
        s_axis_tdata  <= {7'd0, dur, inc, idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        play_beat(k, idx, inc, dur);
        beats_sent++;
    endtask

    task automatic settle();
        @(negedge clk) s_axis_tvalid <= 1'b0;
        while (tone_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic reg_sel, input logic [31:0] value);
        if (playing_now)
            send_beat(KIND_STOP);
        settle();
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge clk) penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_IDX_NOTE_COUNT)
            note_count_reg = value[5:0];
        else
            volume_reg = value[14:0];
        reg_writes++;
    endtask

    task automatic load_random_slot(input logic [4:0] idx);
        logic [15:0] inc;
        logic [19:0] dur;
        inc = ($urandom_range(0, 99) < 15) ? 16'd0 : 16'($urandom);
        dur = ($urandom_range(0, 99) < 10) ? 20'($urandom) : 20'($urandom_range(0, 6));
        send_beat(KIND_LOAD, idx, inc, dur);
    endtask

    task automatic test_idle_commands();
        send_beat(KIND_TICK);
        send_beat(KIND_STOP);
    endtask

    task automatic test_single_melody();
        write_register(REG_IDX_NOTE_COUNT, 32'd3);
        write_register(REG_IDX_VOLUME, 32'd32767);
        send_beat(KIND_LOAD, 5'd0, 16'hFFFF, 20'd5);
        send_beat(KIND_LOAD, 5'd1, 16'h0000, 20'd2);
        send_beat(KIND_LOAD, 5'd2, 16'h0400, 20'd0);
        send_beat(KIND_LOAD, 5'd31, 16'h0001, 20'hFFFFF);
        send_beat(KIND_START);
        send_beat(KIND_TICK);
        // restart request mid-note, then a slot rewrite ahead of the play point
        send_beat(KIND_START);
        send_beat(KIND_LOAD, 5'd2, 16'h8000, 20'd1);
        while (playing_now)
            send_beat(KIND_TICK);
        send_beat(KIND_TICK);
    endtask

    task automatic test_note_count_limits();
        // zero count plays one note, at zero volume
        write_register(REG_IDX_NOTE_COUNT, 32'd0);
        write_register(REG_IDX_VOLUME, 32'd0);
        send_beat(KIND_START);
        while (playing_now)
            send_beat(KIND_TICK);
        // count above the slot total
        write_register(REG_IDX_NOTE_COUNT, 32'd63);
        write_register(REG_IDX_VOLUME, 32'd1);
        send_beat(KIND_START);
        repeat (3) send_beat(KIND_TICK);
        send_beat(KIND_STOP);
    endtask

    task automatic test_random_melodies();
        int unsigned round_no;
        int unsigned ticks;
        int unsigned r;
        for (int i = 0; i < MAX_NOTES; i++)
            load_random_slot(5'(i));
        round_no = 0;
        while (beats_sent < 390)
        begin
            quiet = (round_no >= 3 && round_no < 6);
            if (round_no == 0)
                write_register(REG_IDX_NOTE_COUNT, 32'd32);
            else if ($urandom_range(0, 99) < 60)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    write_register(REG_IDX_NOTE_COUNT, $urandom_range(1, 6));
                else if (r < 80)
                    write_register(REG_IDX_NOTE_COUNT, 32'd0);
                else if (r < 90)
                    write_register(REG_IDX_NOTE_COUNT, 32'd32);
                else
                    write_register(REG_IDX_NOTE_COUNT, $urandom_range(33, 63));
                r = $urandom_range(0, 99);
                if (r < 15)
                    write_register(REG_IDX_VOLUME, 32'd0);
                else if (r < 30)
                    write_register(REG_IDX_VOLUME, 32'd32767);
                else
                    write_register(REG_IDX_VOLUME, $urandom_range(0, 32767));
            end
            repeat ($urandom_range(0, 4))
                load_random_slot(5'($urandom_range(0, MAX_NOTES - 1)));
            send_beat(KIND_START);
            ticks = 0;
            while (playing_now && ticks < 120)
            begin
                r = $urandom_range(0, 99);
                if (r < 85)
                    send_beat(KIND_TICK);
                else if (r < 89)
                    load_random_slot(5'($urandom_range(0, MAX_NOTES - 1)));
                else if (r < 92)
                    send_beat(KIND_START);
                else if (r < 94)
                    send_beat(KIND_STOP);
                else
                    send_beat(kind_t'($urandom_range(0, 3)), 5'($urandom), 16'($urandom),
                              20'($urandom));
                ticks++;
            end
            if (playing_now)
                send_beat(KIND_STOP);
            repeat ($urandom_range(0, 2))
                send_beat(KIND_TICK);
            round_no++;
        end
        quiet = 1'b0;
    endtask

    always @(negedge clk)
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= 36);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (tone_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                failures++;
            end
            else
            begin
                want = tone_results.pop_front();
                if (m_axis_tdata[15:0] !== want.sample)
                begin
                    $error("sample: expected %0d, got %0d", $signed(want.sample),
                           $signed(m_axis_tdata[15:0]));
                    failures++;
                end
                if (m_axis_tuser !== want.sample_valid)
                begin
                    $error("sample_valid: expected %0d, got %0d", want.sample_valid,
                           m_axis_tuser);
                    failures++;
                end
                if (m_axis_tdata[20:16] !== want.note_position)
                begin
                    $error("note_position: expected %0d, got %0d", want.note_position,
                           m_axis_tdata[20:16]);
                    failures++;
                end
                if (m_axis_tdata[21] !== want.playing)
                begin
                    $error("playing: expected %0d, got %0d", want.playing, m_axis_tdata[21]);
                    failures++;
                end
                if (m_axis_tlast !== want.finished)
                begin
                    $error("finished: expected %0d, got %0d", want.finished, m_axis_tlast);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        #(10_000_000);
        $display("tb failed");
        $finish;
    end

    initial
    begin
        int unsigned quad;
        int unsigned r;
        int          v;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_LOAD;
        quiet         = 1'b0;
        failures      = 0;
        beats_sent    = 0;
        samples_played = 0;
        melodies_done = 0;
        reg_writes    = 0;
        for (int i = 0; i < SINE_N; i++)
        begin
            quad = i / (SINE_N / 4);
            r    = i % (SINE_N / 4);
            if (quad % 2 == 1)
                r = SINE_N / 4 - r;
            v = int'((sine_q30(r) * 32767 + (64'd1 << 29)) >> 30);
            sine_wave[i] = (quad >= 2) ? -v : v;
        end
        for (int i = 0; i < MAX_NOTES; i++)
        begin
            tone_step[i] = '0;
            tone_len[i]  = '0;
        end
        phase_acc      = '0;
        len_count      = '0;
        note_now       = '0;
        playing_now    = 1'b0;
        note_count_reg = NOTE_COUNT_RST;
        volume_reg     = VOLUME_RST;

        repeat (10) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_idle_commands();
        test_single_melody();
        test_note_count_limits();
        test_random_melodies();

        @(negedge clk) s_axis_tvalid <= 1'b0;
        for (int n = 0; n < 2000 && tone_results.size() != 0; n++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (tone_results.size() != 0)
        begin
            $error("%0d result beats never arrived", tone_results.size());
            failures++;
        end

        $display("beats sent %0d, register writes %0d", beats_sent, reg_writes);
        $display("samples played %0d, melodies run to the end %0d", samples_played,
                 melodies_done);
        if (failures == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
